/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check on the rising edge of clk, off during reset
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication check
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/sshit_pkg.sv */
`timescale 1ns / 1ps
package sshit_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W = 31;
  localparam int RAD_W = 24;
  localparam int EPS_W = 32;
  localparam int CNT_W = 16;
  localparam int OPND_W = 33;
  localparam int PROD_W = 2 * OPND_W;
  localparam int ACC_W = 64;
  localparam int T_W = FRAC_BITS + 1;
  localparam int CFG_W = 32;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_TEST = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  localparam logic CFG_MIN_RAD = 1'b0;
  localparam logic CFG_EPS = 1'b1;

  localparam logic [RAD_W-1:0] MIN_RAD_RST = RAD_W'(3 << (FRAC_BITS - 2));
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(4295);
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [COORD_W-1:0] abs_coord(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] w;
    w = {v[COORD_W-1], v};
    if (v[COORD_W-1]) w = -w;
    return w[COORD_W-1:0];
  endfunction
endpackage

/* sv/sshit_req_if.sv */
`timescale 1ns / 1ps
interface sshit_req_if;
  import sshit_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic signed [COORD_W-1:0] extra_x;
  logic signed [COORD_W-1:0] extra_y;
  logic signed [COORD_W-1:0] extra_z;
  logic [RAD_W-1:0] sphere_radius;
  logic enemy_alive;
  modport source (output valid, req_type, point_x, point_y, point_z, extra_x, extra_y,
                  extra_z, sphere_radius, enemy_alive, input ready);
  modport sink (input valid, req_type, point_x, point_y, point_z, extra_x, extra_y,
                extra_z, sphere_radius, enemy_alive, output ready);
endinterface

interface sshit_rsp_if;
  import sshit_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  logic skipped;
  logic [CNT_W-1:0] hit_total;
  modport source (output valid, hit, skipped, hit_total, input ready);
  modport sink (input valid, hit, skipped, hit_total, output ready);
endinterface

/* sv/sshit_mult.sv */
`timescale 1ns / 1ps
module sshit_mult (
  input  logic clk,
  input  logic signed [sshit_pkg::OPND_W-1:0] a,
  input  logic signed [sshit_pkg::OPND_W-1:0] b,
  output logic signed [sshit_pkg::PROD_W-1:0] prod
);
  import sshit_pkg::*;
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end
endmodule

/* sv/sshit_div.sv */
`timescale 1ns / 1ps
module sshit_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [sshit_pkg::ACC_W-1:0] num,
  input  logic [sshit_pkg::ACC_W-1:0] den,
  output sshit_pkg::div_stat_t stat,
  output logic [sshit_pkg::FRAC_BITS-1:0] quot
);
  import sshit_pkg::*;
  localparam int CW = $clog2(FRAC_BITS + 1);
  logic [ACC_W-1:0] rem;
  logic [ACC_W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic busy;
  logic done;
  logic [ACC_W:0] shifted;
  logic ge;

  assign shifted = {rem, 1'b0};
  assign ge = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
      quot <= '0;
    end else if (busy) begin
      rem <= ge ? ACC_W'(shifted - {1'b0, dvs}) : shifted[ACC_W-1:0];
      quot <= {quot[FRAC_BITS-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule

/* sv/swept_sphere_hit_test_unit.sv */
`timescale 1ns / 1ps
// channel | dir | beat
// req     | in  | req_type, point_x/y/z, extra_x/y/z, sphere_radius, enemy_alive
// rsp     | out | hit, skipped, hit_total (one per test request)
// cfg     | in  | cfg_we, cfg_index, cfg_data (no handshake)
// Start and load requests are handled in ST_IDLE; a skipped test passes through ST_FIN.
// A full test takes 13 passes of the shared 33x33 multiplier, each an ST_MUL and an ST_ACC state,
// plus an ST_DIV wait when the 16-step restoring divider forms the fraction.
// req is ready only while idle; a finished beat waits in the rsp register.
// rst is synchronous and active high.
`include "assert_macros.svh"
module swept_sphere_hit_test_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [sshit_pkg::CFG_W-1:0] cfg_data,
  sshit_req_if.sink req,
  sshit_rsp_if.source rsp
);
  import sshit_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    PH_LEN  = 5'b00001,
    PH_DOT  = 5'b00010,
    PH_PT   = 5'b00100,
    PH_DIST = 5'b01000,
    PH_RAD  = 5'b10000
  } phase_t;

  state_t state;
  phase_t phase;
  logic [1:0] axis;

  logic [RAD_W-1:0] min_rad;
  logic [EPS_W-1:0] eps;

  logic signed [COORD_W-1:0] seg_start [3];
  logic signed [COORD_W-1:0] seg_end [3];
  logic [RAD_W-1:0] proj_radius;
  logic proj_done;
  logic [CNT_W-1:0] hit_count;

  logic signed [COORD_W:0] dv [3];
  logic signed [COORD_W:0] rel [3];
  logic signed [COORD_W-1:0] ev [3];
  logic signed [OPND_W-1:0] dl [3];
  logic [COORD_W:0] comb;
  logic [ACC_W-1:0] lensq;
  logic signed [PROD_W-1:0] dot;
  logic signed [PROD_W-1:0] dot_next;
  logic [ACC_W-1:0] dist2;
  logic [T_W-1:0] tval;
  logic res_hit;
  logic res_skip;

  logic signed [OPND_W-1:0] op_a;
  logic signed [OPND_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic div_start;
  div_stat_t div_st;
  logic [FRAC_BITS-1:0] quot;

  logic out_valid;
  logic out_hit;
  logic out_skip;
  logic [CNT_W-1:0] out_total;

  logic in_acc;
  logic signed [COORD_W-1:0] pin [3];
  logic signed [COORD_W-1:0] xin [3];
  logic [COORD_W-1:0] rad_in;
  logic signed [PROD_W-1:0] cpt;
  logic signed [OPND_W:0] dl_new;
  logic last_axis;
  logic out_free;

  assign pin[0] = req.point_x;
  assign pin[1] = req.point_y;
  assign pin[2] = req.point_z;
  assign xin[0] = req.extra_x;
  assign xin[1] = req.extra_y;
  assign xin[2] = req.extra_z;

  assign req.ready = (state == ST_IDLE);
  assign in_acc = req.valid && req.ready;
  assign last_axis = (axis == 2'd2);
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    logic [COORD_W-1:0] m;
    m = {{(COORD_W-RAD_W){1'b0}}, min_rad};
    for (int i = 0; i < 3; i++) begin
      if (abs_coord(xin[i]) > m) m = abs_coord(xin[i]);
    end
    rad_in = m;
  end

  always_comb begin
    unique case (phase)
      PH_LEN: begin
        op_a = OPND_W'(dv[axis]);
        op_b = OPND_W'(dv[axis]);
      end
      PH_DOT: begin
        op_a = OPND_W'(rel[axis]);
        op_b = OPND_W'(dv[axis]);
      end
      PH_PT: begin
        op_a = OPND_W'(dv[axis]);
        op_b = $signed({{(OPND_W-T_W){1'b0}}, tval});
      end
      PH_DIST: begin
        op_a = dl[axis];
        op_b = dl[axis];
      end
      PH_RAD: begin
        op_a = $signed({1'b0, comb});
        op_b = $signed({1'b0, comb});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  sshit_mult u_mult (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .prod(prod)
  );

  assign dot_next = dot + prod;
  assign div_start = (state == ST_ACC) && (phase == PH_DOT) && last_axis
                     && !(lensq <= ACC_W'(eps)) && (dot_next > 0)
                     && (dot_next < $signed({2'b00, lensq}));

  sshit_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (dot_next[ACC_W-1:0]),
    .den  (lensq),
    .stat (div_st),
    .quot (quot)
  );

  assign cpt = PROD_W'(seg_start[axis]) + (prod >>> FRAC_BITS);
  assign dl_new = (OPND_W+1)'(ev[axis]) - (OPND_W+1)'(cpt);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rad <= MIN_RAD_RST;
      eps <= EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_RAD: min_rad <= cfg_data[RAD_W-1:0];
        CFG_EPS: eps <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_LEN;
      axis <= 2'd0;
      proj_done <= 1'b1;
      hit_count <= '0;
      proj_radius <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        seg_start[i] <= '0;
        seg_end[i] <= '0;
      end
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (req.req_type)
              REQ_START: hit_count <= '0;
              REQ_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                  seg_start[i] <= pin[i];
                  seg_end[i] <= xin[i];
                end
                proj_radius <= req.sphere_radius;
                proj_done <= 1'b0;
              end
              REQ_TEST: begin
                phase <= PH_LEN;
                axis <= 2'd0;
                if (proj_done || !req.enemy_alive) state <= ST_FIN;
                else state <= ST_MUL;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          state <= ST_MUL;
          axis <= last_axis ? 2'd0 : axis + 2'd1;
          unique case (phase)
            PH_LEN: if (last_axis) phase <= PH_DOT;
            PH_DOT: begin
              if (last_axis) begin
                phase <= PH_PT;
                if (div_start) state <= ST_DIV;
              end
            end
            PH_PT: if (last_axis) phase <= PH_DIST;
            PH_DIST: if (last_axis) phase <= PH_RAD;
            PH_RAD: state <= ST_FIN;
            default: ;
          endcase
        end
        ST_DIV: if (div_st.done) state <= ST_MUL;
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= ST_IDLE;
            if (res_hit) begin
              proj_done <= 1'b1;
              if (hit_count != {CNT_W{1'b1}}) hit_count <= hit_count + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      for (int i = 0; i < 3; i++) begin
        dv[i] <= (COORD_W+1)'(seg_end[i]) - (COORD_W+1)'(seg_start[i]);
        rel[i] <= (COORD_W+1)'(pin[i]) - (COORD_W+1)'(seg_start[i]);
        ev[i] <= pin[i];
      end
      comb <= (COORD_W+1)'(rad_in) + (COORD_W+1)'(proj_radius);
      lensq <= '0;
      dot <= '0;
      dist2 <= '0;
      tval <= '0;
      res_hit <= 1'b0;
      res_skip <= proj_done || !req.enemy_alive;
    end else if (state == ST_ACC) begin
      unique case (phase)
        PH_LEN: lensq <= lensq + prod[ACC_W-1:0];
        PH_DOT: begin
          dot <= dot_next;
          if (last_axis && !div_start && !(lensq <= ACC_W'(eps)) && dot_next > 0)
            tval <= T_ONE;
        end
        PH_PT: dl[axis] <= dl_new[OPND_W-1:0];
        PH_DIST: dist2 <= dist2 + prod[ACC_W-1:0];
        PH_RAD: res_hit <= dist2 <= prod[ACC_W-1:0];
        default: ;
      endcase
    end else if (state == ST_DIV && div_st.done) begin
      tval <= {1'b0, quot};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_hit <= res_hit;
      out_skip <= res_skip;
      if (res_hit && hit_count != {CNT_W{1'b1}}) out_total <= hit_count + CNT_W'(1);
      else out_total <= hit_count;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.hit = out_hit;
  assign rsp.skipped = out_skip;
  assign rsp.hit_total = out_total;

  `CHK_IMPL(a_hit_skip_excl, out_valid, !(out_hit && out_skip), "hit and skipped both set")
  `CHK_IMPL(a_div_in_wait, div_st.busy, state == ST_DIV, "divider busy outside wait")
  `CHK_IMPL(a_done_on_hit, $rose(proj_done), out_valid && out_hit, "done set without hit")
  `CHK_NEXT(a_fin_loads_out, state == ST_FIN && out_free, out_valid, "result not loaded")
endmodule

/* test/swept_sphere_hit_test_unit_tb.sv */
`timescale 1ns / 1ps
module swept_sphere_hit_test_unit_tb;
  import sshit_pkg::*;

  typedef struct {
    logic [1:0] kind;
    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] ex [3];
    logic [RAD_W-1:0] radius;
    logic alive;
  } hit_req_t;

  typedef struct {
    logic hit;
    logic skipped;
    logic [CNT_W-1:0] total;
  } hit_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  sshit_req_if req_ch ();
  sshit_rsp_if rsp_ch ();

  swept_sphere_hit_test_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  longint seg_a [3];
  longint seg_b [3];
  longint proj_rad;
  bit proj_hit;
  int unsigned pass_hits;
  longint unsigned min_rad;
  longint unsigned len_eps;

  hit_rsp_t pending_rsps [$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int hold_off = 0;
  int stall_ask = 0;
  int stall_seen = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_START;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.point_z = '0;
    req_ch.extra_x = '0;
    req_ch.extra_y = '0;
    req_ch.extra_z = '0;
    req_ch.sphere_radius = '0;
    req_ch.enemy_alive = 1'b0;
    rsp_ch.ready = 1'b0;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint floor_frac(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic void predict_hit(hit_req_t r);
    longint dv [3];
    longint ev [3];
    longint unsigned lensq, pos, neg, dist2, rad, comb, t, rem, s;
    longint rel, p, c, dl;
    bit carry;
    hit_rsp_t o;
    lensq = 0; pos = 0; neg = 0; dist2 = 0;
    case (r.kind)
      REQ_START: begin
        pass_hits = 0;
        return;
      end
      REQ_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          seg_a[i] = r.pt[i];
          seg_b[i] = r.ex[i];
        end
        proj_rad = r.radius;
        proj_hit = 1'b0;
        return;
      end
      REQ_TEST: ;
      default: return;
    endcase
    if (proj_hit || !r.alive) begin
      o.hit = 1'b0; o.skipped = 1'b1; o.total = pass_hits[CNT_W-1:0];
      pending_rsps.insert(pending_rsps.size(), o);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      dv[i] = seg_b[i] - seg_a[i];
      ev[i] = r.pt[i];
      lensq += mag64(dv[i]) * mag64(dv[i]);
      rel = ev[i] - seg_a[i];
      p = rel * dv[i];
      if (p >= 0) pos += p;
      else neg += longint'(-p);
    end
    if (lensq <= len_eps || pos <= neg) begin
      t = 0;
    end else if (pos - neg >= lensq) begin
      t = 64'd1 << FRAC_BITS;
    end else begin
      rem = pos - neg;
      t = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        carry = rem[63];
        rem = rem << 1;
        t = t << 1;
        if (carry || rem >= lensq) begin
          rem -= lensq;
          t |= 1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      c = seg_a[i] + floor_frac(dv[i] * longint'(t));
      dl = ev[i] - c;
      dist2 += mag64(dl) * mag64(dl);
    end
    rad = min_rad;
    for (int i = 0; i < 3; i++) begin
      s = mag64(longint'(r.ex[i]));
      if (s > rad) rad = s;
    end
    comb = rad + proj_rad;
    o.hit = dist2 <= comb * comb;
    o.skipped = 1'b0;
    if (o.hit) begin
      proj_hit = 1'b1;
      if (pass_hits < 65535) pass_hits++;
    end
    o.total = pass_hits[CNT_W-1:0];
    pending_rsps.insert(pending_rsps.size(), o);
  endfunction

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_beat(hit_req_t r);
    idle_gap();
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.point_x <= r.pt[0];
    req_ch.point_y <= r.pt[1];
    req_ch.point_z <= r.pt[2];
    req_ch.extra_x <= r.ex[0];
    req_ch.extra_y <= r.ex[1];
    req_ch.extra_z <= r.ex[2];
    req_ch.sphere_radius <= r.radius;
    req_ch.enemy_alive <= r.alive;
    do @(posedge clk); while (!req_ch.ready);
    predict_hit(r);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat hit=%0b skipped=%0b total=%0d",
                                   rsp_ch.hit, rsp_ch.skipped, rsp_ch.hit_total);
      end else begin
        hit_rsp_t e;
        e = pending_rsps.pop_front();
        if (e.hit !== rsp_ch.hit || e.skipped !== rsp_ch.skipped ||
            e.total !== rsp_ch.hit_total) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp hit=%0b skipped=%0b total=%0d got %0b %0b %0d",
                     e.hit, e.skipped, e.total, rsp_ch.hit, rsp_ch.skipped,
                     rsp_ch.hit_total);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      hold_off <= 400;
      rsp_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 5);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_RAD) min_rad = val[RAD_W-1:0];
    else len_eps = val;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(0, 2 * 262144)) - 262144);
      default: return COORD_W'($signed($urandom_range(0, 2 * 16777216)) - 16777216);
    endcase
  endfunction

  function automatic hit_req_t make_req(logic [1:0] kind, int mode);
    hit_req_t r;
    r.kind = kind;
    for (int i = 0; i < 3; i++) begin
      r.pt[i] = rand_coord(mode);
      r.ex[i] = $urandom_range(0, 3) == 0 ? rand_coord(mode) : rand_coord(1) >>> 2;
    end
    r.radius = $urandom_range(0, 1) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 200000));
    r.alive = $urandom_range(0, 5) != 0;
    return r;
  endfunction

  task automatic test_directed();
    hit_req_t r;
    r = make_req(REQ_TEST, 1);
    r.alive = 1'b1;
    send_beat(r);
    r.kind = REQ_START;
    send_beat(r);
    r.kind = REQ_RSVD;
    send_beat(r);
    r = make_req(REQ_LOAD, 1);
    for (int i = 0; i < 3; i++) begin
      r.pt[i] = COORD_W'(-1073741824);
      r.ex[i] = COORD_W'(1073741823);
    end
    r.radius = '1;
    send_beat(r);
    r.kind = REQ_TEST;
    r.alive = 1'b0;
    send_beat(r);
    r.alive = 1'b1;
    send_beat(r);
    send_beat(r);
    r = make_req(REQ_LOAD, 1);
    for (int i = 0; i < 3; i++) r.ex[i] = r.pt[i];
    r.radius = '0;
    send_beat(r);
    r.kind = REQ_TEST;
    r.alive = 1'b1;
    for (int i = 0; i < 3; i++) r.ex[i] = COORD_W'(-1073741824);
    send_beat(r);
    r = make_req(REQ_LOAD, 1);
    r.radius = '0;
    send_beat(r);
    r = make_req(REQ_TEST, 2);
    r.alive = 1'b1;
    for (int i = 0; i < 3; i++) r.ex[i] = '0;
    send_beat(r);
    drain();
  endtask

  task automatic test_saturation();
    hit_req_t r;
    r = make_req(REQ_LOAD, 1);
    r.radius = '1;
    for (int n = 0; n < 3; n++) begin
      r.kind = REQ_LOAD;
      send_beat(r);
      r.kind = REQ_TEST;
      r.alive = 1'b1;
      send_beat(r);
    end
    drain();
  endtask

  task automatic test_random(int count, int mode);
    hit_req_t r;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 19);
      if (k == 0) r = make_req(REQ_START, mode);
      else if (k == 1) r = make_req(REQ_RSVD, mode);
      else if (k < 6) r = make_req(REQ_LOAD, mode);
      else r = make_req(REQ_TEST, mode);
      send_beat(r);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hit_req_t r;
    stall_ask++;
    for (int n = 0; n < 12; n++) begin
      r = make_req(n % 3 == 0 ? REQ_LOAD : REQ_TEST, 1);
      send_beat(r);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      seg_a[i] = 0;
      seg_b[i] = 0;
    end
    proj_rad = 0;
    proj_hit = 1'b1;
    pass_hits = 0;
    min_rad = MIN_RAD_RST;
    len_eps = EPS_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random(250, 1);
    write_reg(CFG_MIN_RAD, 32'hFFFFFF);
    write_reg(CFG_EPS, 32'hFFFFFFFF);
    test_random(120, 0);
    write_reg(CFG_MIN_RAD, 32'h0);
    write_reg(CFG_EPS, 32'h0);
    test_backpressure();
    test_random(250, 2);
    write_reg(CFG_MIN_RAD, 32'h0000C000);
    write_reg(CFG_EPS, 32'd4295);
    test_random(150, 1);
    idle_on = 1'b0;
    test_random(150, 1);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* swept_sphere_hit_test_unit.f */
+incdir+sv
sv/sshit_pkg.sv
sv/sshit_req_if.sv
sv/sshit_mult.sv
sv/sshit_div.sv
sv/swept_sphere_hit_test_unit.sv
test/swept_sphere_hit_test_unit_tb.sv
